// ----- design/cnc_pkg.sv -----
// Shared types, constants and the hit-count bucketing function of the novelty checker.
`default_nettype none
package cnc_pkg;

    localparam int IDX_W       = 13;
    localparam int WORD_W      = 64;
    localparam int VERDICT_W   = 2;
    localparam int COUNT_W     = 17;
    localparam int BYTES_PER_W = 8;
    localparam int NEWLY_W     = 4;

    localparam int MAP_BYTES_DEF = 65536;
    localparam int MID_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 4;

    localparam logic [COUNT_W-1:0]   COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [7:0]           BYTE_FULL = 8'hFF;

    localparam logic [VERDICT_W-1:0] VERDICT_NONE   = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_BUCKET = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_NEW    = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0]  word_index;
        logic [WORD_W-1:0] trace_word;
        logic              last_word;
    } t_in;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic [COUNT_W-1:0]   covered_bytes;
    } t_out;

    typedef struct packed {
        logic [IDX_W-1:0]  word_index;
        logic [WORD_W-1:0] classified;
        logic              last_word;
    } t_work;

    function automatic logic [7:0] bucket_byte(input logic [7:0] c);
        logic [7:0] r;
        case (c) inside
            [8'd0:8'd2]:     r = c;
            8'd3:            r = 8'd4;
            [8'd4:8'd7]:     r = 8'd8;
            [8'd8:8'd15]:    r = 8'd16;
            [8'd16:8'd31]:   r = 8'd32;
            [8'd32:8'd127]:  r = 8'd64;
            default:         r = 8'd128;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- design/coverage_novelty_check.sv -----
// Top level of the coverage novelty checker: front end, work queue and virgin map back end.
//
//   Channel   Handshake        Payload            Request
//   input     push / full      i_item  (t_in)     one 64-bit trace word
//   result    empty / pop      o_result (t_out)   verdict and covered byte count
//
// One trace word is taken per cycle while full is low; the virgin map RAM does one read
// and one write per cycle; words pass the work queue and stage r_s1 into the result queue.
// After reset the map RAM is set to all ones, one word per cycle, over all MAP_BYTES/8
// words (8192 by default); full stays high during that pass.
// A stalled result side fills the result queue, then the work queue, then raises full.
`default_nettype none
module coverage_novelty_check #(
    parameter int MAP_BYTES = cnc_pkg::MAP_BYTES_DEF,
    parameter int MID_DEPTH = cnc_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = cnc_pkg::OUT_DEPTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         push,
    input  wire cnc_pkg::t_in i_item,
    output logic              full,
    output logic              empty,
    input  wire logic         pop,
    output cnc_pkg::t_out     o_result
);
    cnc_pkg::t_work work;
    logic           work_empty;
    logic           work_pop;
    logic           busy;

    cnc_front #(
        .MID_DEPTH (MID_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .i_item       (i_item),
        .full         (full),
        .i_busy       (busy),
        .i_work_pop   (work_pop),
        .o_work       (work),
        .o_work_empty (work_empty)
    );

    cnc_back #(
        .MAP_BYTES (MAP_BYTES),
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work       (work),
        .i_work_empty (work_empty),
        .o_work_pop   (work_pop),
        .o_busy       (busy),
        .empty        (empty),
        .pop          (pop),
        .o_result     (o_result)
    );
endmodule
`default_nettype wire

// ----- design/cnc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module cnc_ram #(
    parameter int W     = 64,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [W-1:0]             i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ----- design/cnc_fifo.sv -----
// Small register-based first-in first-out queue.
`default_nettype none
module cnc_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [W-1:0]               i_data,
    output logic                            o_full,
    input  wire logic                       i_pop,
    output logic      [W-1:0]               o_data,
    output logic                            o_empty,
    output logic      [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end
endmodule
`default_nettype wire

// ----- design/cnc_front.sv -----
// Front end: accepts trace words, buckets their hit counts and queues them for the back end.
`default_nettype none
module cnc_front #(
    parameter int MID_DEPTH = cnc_pkg::MID_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    input  wire cnc_pkg::t_in  i_item,
    output logic               full,
    input  wire logic          i_busy,
    input  wire logic          i_work_pop,
    output cnc_pkg::t_work     o_work,
    output logic               o_work_empty
);
    cnc_pkg::t_work work_in;
    logic           mid_full;

    always_comb begin
        work_in.word_index = i_item.word_index;
        work_in.last_word  = i_item.last_word;
        for (int b = 0; b < cnc_pkg::BYTES_PER_W; b++) begin
            work_in.classified[8*b +: 8] = cnc_pkg::bucket_byte(i_item.trace_word[8*b +: 8]);
        end
    end

    assign full = mid_full || i_busy;

    cnc_fifo #(
        .W     ($bits(cnc_pkg::t_work)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && !i_busy),
        .i_data  (work_in),
        .o_full  (mid_full),
        .i_pop   (i_work_pop),
        .o_data  (o_work),
        .o_empty (o_work_empty),
        .o_count ()
    );
endmodule
`default_nettype wire

// ----- design/cnc_back.sv -----
// Back end: virgin map read-modify-write, verdict and count tracking, result queue.
`default_nettype none
module cnc_back #(
    parameter int MAP_BYTES = cnc_pkg::MAP_BYTES_DEF,
    parameter int OUT_DEPTH = cnc_pkg::OUT_DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire cnc_pkg::t_work i_work,
    input  wire logic           i_work_empty,
    output logic                o_work_pop,
    output logic                o_busy,
    output logic                empty,
    input  wire logic           pop,
    output cnc_pkg::t_out       o_result
);
    localparam int MAP_WORDS = MAP_BYTES / 8;
    localparam int ADDR_W    = $clog2(MAP_WORDS);
    localparam int CMP_W     = ((ADDR_W > cnc_pkg::IDX_W) ? ADDR_W : cnc_pkg::IDX_W) + 1;
    localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);
    localparam int W         = cnc_pkg::WORD_W;

    logic                        r_clr;
    logic [ADDR_W-1:0]           r_clr_addr;
    logic                        r_s1_valid;
    cnc_pkg::t_work              r_s1;
    logic                        r_fwd_valid;
    logic [ADDR_W-1:0]           r_fwd_addr;
    logic [W-1:0]                r_fwd_data;
    logic [cnc_pkg::VERDICT_W-1:0] r_verdict, n_verdict, verdict_upd;
    logic [cnc_pkg::COUNT_W-1:0]   r_count, n_count;

    logic [OCNT_W-1:0]           out_count;
    logic                        issue;
    logic [ADDR_W-1:0]           rd_addr, s1_addr;
    logic                        s1_in_range;
    logic [W-1:0]                rd_data, vir, cur, nv;
    logic                        hit, fresh, map_we;
    logic [cnc_pkg::NEWLY_W-1:0] newly;
    logic [cnc_pkg::COUNT_W:0]   count_sum;
    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [W-1:0]                ram_wdata;
    cnc_pkg::t_out               result_in;
    logic                        out_full;

    assign o_busy     = r_clr;
    assign issue      = !i_work_empty && !r_clr && (out_count <= OCNT_W'(OUT_DEPTH - 2));
    assign o_work_pop = issue;
    assign rd_addr    = ADDR_W'(CMP_W'(i_work.word_index));
    assign s1_addr    = ADDR_W'(CMP_W'(r_s1.word_index));
    assign s1_in_range = CMP_W'(r_s1.word_index) < CMP_W'(MAP_WORDS);

    always_comb begin
        cur   = r_s1.classified;
        vir   = (r_fwd_valid && r_fwd_addr == s1_addr) ? r_fwd_data : rd_data;
        nv    = vir & ~cur;
        hit   = r_s1_valid && s1_in_range && (cur != '0) && ((cur & vir) != '0);
        fresh = 1'b0;
        newly = '0;
        for (int b = 0; b < cnc_pkg::BYTES_PER_W; b++) begin
            if (cur[8*b +: 8] != 8'd0 && vir[8*b +: 8] == cnc_pkg::BYTE_FULL) begin
                fresh = 1'b1;
            end
            if (vir[8*b +: 8] == cnc_pkg::BYTE_FULL && nv[8*b +: 8] != cnc_pkg::BYTE_FULL) begin
                newly = newly + 1'b1;
            end
        end
        map_we = hit;

        verdict_upd = r_verdict;
        if (hit && r_verdict != cnc_pkg::VERDICT_NEW) begin
            verdict_upd = fresh ? cnc_pkg::VERDICT_NEW : cnc_pkg::VERDICT_BUCKET;
        end
        count_sum = {1'b0, r_count} + (cnc_pkg::COUNT_W + 1)'(newly);
        n_count   = r_count;
        if (hit) begin
            n_count = (count_sum > {1'b0, cnc_pkg::COUNT_MAX}) ?
                      cnc_pkg::COUNT_MAX : count_sum[cnc_pkg::COUNT_W-1:0];
        end
        n_verdict = (r_s1_valid && r_s1.last_word) ? cnc_pkg::VERDICT_NONE : verdict_upd;

        result_in.verdict       = verdict_upd;
        result_in.covered_bytes = n_count;

        ram_we    = r_clr || map_we;
        ram_waddr = r_clr ? r_clr_addr : s1_addr;
        ram_wdata = r_clr ? {W{1'b1}} : nv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_verdict   <= cnc_pkg::VERDICT_NONE;
            r_count     <= '0;
        end else begin
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(MAP_WORDS - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            r_s1_valid  <= issue;
            r_fwd_valid <= map_we;
            if (r_s1_valid) begin
                r_verdict <= n_verdict;
                r_count   <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1 <= i_work;
        end
        r_fwd_addr <= s1_addr;
        r_fwd_data <= nv;
    end

    cnc_ram #(
        .W     (W),
        .DEPTH (MAP_WORDS)
    ) u_virgin_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (issue),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    cnc_fifo #(
        .W     ($bits(cnc_pkg::t_out)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid && r_s1.last_word && !out_full),
        .i_data  (result_in),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty),
        .o_count (out_count)
    );
endmodule
`default_nettype wire
